// ===== rtl/rgbad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbad_pkg: shared types and constants of the RGB565 area-average downscaler
// Configuration indexes, reset values, channel codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rgbad_pkg;

    localparam int DEF_MAX_TARGET = 128;
    localparam int DEF_MAX_SOURCE = 1024;
    localparam int DEF_MAX_WINDOW = 16;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_CFG_W   = 10;
    localparam int TGT_CFG_W   = 8;
    localparam int PIX_W       = 16;
    localparam int COORD_W     = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_EDGE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_EDGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_TOP      = 3'd5;

    localparam logic [CFG_W-1:0]     RST_SOURCE_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0]     RST_SOURCE_HEIGHT = 11'd320;
    localparam logic [CFG_W-1:0]     RST_CROP_EDGE     = 11'd320;
    localparam logic [TGT_CFG_W-1:0] RST_TARGET_EDGE   = 8'd96;
    localparam logic [POS_CFG_W-1:0] RST_CROP_POS      = 10'd0;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       rst_div;
        logic       rst_load;
        logic       mem_read;
        logic       update;
        logic       ch_div;
        logic       ch_store;
        logic [1:0] ch;
        logic       out_load;
        logic       adv;
        logic       adv_store;
    } t_cmd;

    typedef struct packed {
        logic restart_due;
        logic div_done;
        logic emit;
        logic out_full;
        logic adv_div;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/rgbad_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbad_div: iterative restoring divider
// One quotient bit per cycle; done pulses in the cycle after the last bit.
// ----------------------------------------------------------------------------
module rgbad_div #(
    parameter int N_W = 21,
    parameter int D_W = 9
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(N_W + 1);

    // The partial remainder stays below the divisor, so D_W bits hold it.
    logic [D_W-1:0] r_rem;
    logic [N_W-1:0] r_quot;
    logic [D_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic           r_done;
    logic [D_W:0]   rem_sh;
    logic [D_W+1:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_quot[N_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = ~diff[D_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(N_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
            r_quot <= {r_quot[N_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ===== rtl/rgbad_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbad_dp: datapath of the downscaler
// Configuration and geometry registers, source and output position, the
// per-column accumulator memory, the shared divider and the output register.
// ----------------------------------------------------------------------------
module rgbad_dp
    import rgbad_pkg::*;
#(
    parameter int MAX_TARGET = DEF_MAX_TARGET,
    parameter int MAX_SOURCE = DEF_MAX_SOURCE,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                   i_s_axis_tuser,
    input  wire logic                   i_m_axis_tready,
    output logic                        o_m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status
);
    localparam int SRC_W  = $clog2(MAX_SOURCE);
    localparam int EDGE_W = ((POS_CFG_W > SRC_W) ? POS_CFG_W : SRC_W) + 2;
    localparam int T_W    = $clog2(MAX_TARGET + 1);
    localparam int IDX_W  = T_W + 1;
    localparam int ADDR_W = $clog2(MAX_TARGET);
    localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int PROD_W = IDX_W + EDGE_W;
    localparam int DIV_N  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam int DIV_D  = (CNT_W > T_W) ? CNT_W : T_W;
    localparam int GW     = EDGE_W + T_W + 7;

    // configuration
    logic [CFG_W-1:0]     r_cfg_w, r_cfg_h, r_cfg_c;
    logic [TGT_CFG_W-1:0] r_cfg_t;
    logic [POS_CFG_W-1:0] r_cfg_l, r_cfg_top;

    // geometry clamp
    logic [GW-1:0] g_w, g_h, g_c, g_t, g_mw;
    logic [EDGE_W-1:0] eff_w_c, eff_h_c, eff_c_c;
    logic [T_W-1:0]    eff_t_c;

    logic [EDGE_W-1:0] r_eff_w, r_eff_h, r_eff_c;
    logic [T_W-1:0]    r_eff_t;

    // position state
    logic [SRC_W-1:0]  r_sc, r_sr;
    logic [T_W-1:0]    r_ocol, r_orow;
    logic [EDGE_W-1:0] r_col_end, r_row_end, r_col_start, r_q1;
    logic              r_band, r_restart_due;

    logic [PIX_W-1:0]  r_pix;

    // accumulators
    logic [2:0][SUM_W-1:0] r_mem_sum [MAX_TARGET];
    logic [CNT_W-1:0]      r_mem_cnt [MAX_TARGET];
    logic [2:0][SUM_W-1:0] r_rd_sum, r_acc_sum, new_sum;
    logic [CNT_W-1:0]      r_rd_cnt, r_acc_cnt, new_cnt;
    logic [2:0][7:0]       pix8;

    logic [2:0][7:0]       r_avg;
    logic [COORD_W-1:0]    r_ex, r_ey;
    logic                  r_elast;

    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [EDGE_W-1:0] sc_e, sr_e, sc1, sr1, cl_e, ct_e;
    logic incol, inrow, first, x_end, y_end, emit, last_x, last_y;
    logic row_wrap, col_step, row_step, last_row, adv_div, r_kind_row;
    logic [ADDR_W-1:0] addr;

    logic [IDX_W-1:0]  adv_idx;
    logic [PROD_W-1:0] adv_prod;

    logic              div_start, div_done;
    logic [DIV_N-1:0]  div_num, div_quot;
    logic [DIV_D-1:0]  div_den;
    logic [SUM_W-1:0]  ch_sum;

    always_comb begin
        g_w = GW'(r_cfg_w);
        g_h = GW'(r_cfg_h);
        g_c = GW'(r_cfg_c);
        g_t = GW'(r_cfg_t);
        if (g_w == '0) g_w = GW'(1);
        else if (g_w > GW'(MAX_SOURCE)) g_w = GW'(MAX_SOURCE);
        if (g_h == '0) g_h = GW'(1);
        else if (g_h > GW'(MAX_SOURCE)) g_h = GW'(MAX_SOURCE);
        if (g_c == '0) g_c = GW'(1);
        else if (g_c > GW'(MAX_SOURCE)) g_c = GW'(MAX_SOURCE);
        if (g_t == '0) g_t = GW'(1);
        else if (g_t > GW'(MAX_TARGET)) g_t = GW'(MAX_TARGET);
        if (g_t > g_c) g_t = g_c;
        g_mw = g_t * GW'(MAX_WINDOW);
        if (g_c > g_mw) g_c = g_mw;
        eff_w_c = EDGE_W'(g_w);
        eff_h_c = EDGE_W'(g_h);
        eff_c_c = EDGE_W'(g_c);
        eff_t_c = T_W'(g_t);
    end

    always_comb begin
        sc_e  = EDGE_W'(r_sc);
        sr_e  = EDGE_W'(r_sr);
        sc1   = sc_e + EDGE_W'(1);
        sr1   = sr_e + EDGE_W'(1);
        cl_e  = EDGE_W'(r_cfg_l);
        ct_e  = EDGE_W'(r_cfg_top);
        incol = (sc_e >= cl_e) && (sc_e < cl_e + r_eff_c) && (r_ocol < r_eff_t);
        inrow = (sr_e >= ct_e) && (sr_e < ct_e + r_eff_c) && (r_orow < r_eff_t);
        first = r_band && (sc_e == r_col_start);
        x_end = (sc1 == r_col_end) || (sc1 >= r_eff_w);
        y_end = (sr1 == r_row_end) || (sr1 >= r_eff_h);
        emit  = incol && inrow && x_end && y_end;
        last_x = (IDX_W'(r_ocol) + IDX_W'(1) >= IDX_W'(r_eff_t)) || (r_col_end >= r_eff_w);
        last_y = (IDX_W'(r_orow) + IDX_W'(1) >= IDX_W'(r_eff_t)) || (r_row_end >= r_eff_h);
        addr  = ADDR_W'(r_ocol);

        pix8[0] = {r_pix[15:11], 3'b000};
        pix8[1] = {r_pix[10:5], 2'b00};
        pix8[2] = {r_pix[4:0], 3'b000};
        for (int k = 0; k < 3; k++) begin
            new_sum[k] = first ? SUM_W'(pix8[k]) : r_rd_sum[k] + SUM_W'(pix8[k]);
        end
        new_cnt = first ? CNT_W'(1) : r_rd_cnt + CNT_W'(1);

        row_wrap = sc1 >= r_eff_w;
        col_step = incol && (sc1 == r_col_end);
        row_step = inrow && (sr1 == r_row_end);
        last_row = sr1 >= r_eff_h;
        adv_div  = row_wrap ? (row_step && !last_row) : col_step;
        adv_idx  = row_wrap ? IDX_W'(r_orow) + IDX_W'(2) : IDX_W'(r_ocol) + IDX_W'(2);
        adv_prod = PROD_W'(adv_idx) * PROD_W'(r_eff_c);
    end

    always_comb begin
        case (i_cmd.ch)
            CH_RED:   ch_sum = r_acc_sum[0];
            CH_GREEN: ch_sum = r_acc_sum[1];
            default:  ch_sum = r_acc_sum[2];
        endcase
        div_start = i_cmd.rst_div || i_cmd.ch_div || (i_cmd.adv && adv_div);
        if (i_cmd.ch_div) begin
            div_num = DIV_N'(ch_sum);
            div_den = DIV_D'(r_acc_cnt);
        end else if (i_cmd.adv) begin
            div_num = DIV_N'(adv_prod);
            div_den = DIV_D'(r_eff_t);
        end else begin
            div_num = DIV_N'(eff_c_c);
            div_den = DIV_D'(eff_t_c);
        end
    end

    rgbad_div #(
        .N_W (DIV_N),
        .D_W (DIV_D)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w       <= RST_SOURCE_WIDTH;
            r_cfg_h       <= RST_SOURCE_HEIGHT;
            r_cfg_c       <= RST_CROP_EDGE;
            r_cfg_t       <= RST_TARGET_EDGE;
            r_cfg_l       <= RST_CROP_POS;
            r_cfg_top     <= RST_CROP_POS;
            r_restart_due <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end
            if (i_cmd.rst_load) begin
                r_restart_due <= 1'b0;
            end
            if (i_cmd.adv && row_wrap && last_row) begin
                r_restart_due <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SOURCE_WIDTH: begin
                        r_cfg_w <= i_cfg_data;
                        r_restart_due <= 1'b1;
                    end
                    CFG_SOURCE_HEIGHT: begin
                        r_cfg_h <= i_cfg_data;
                        r_restart_due <= 1'b1;
                    end
                    CFG_CROP_EDGE: begin
                        r_cfg_c <= i_cfg_data;
                        r_restart_due <= 1'b1;
                    end
                    CFG_TARGET_EDGE: begin
                        r_cfg_t <= i_cfg_data[TGT_CFG_W-1:0];
                        r_restart_due <= 1'b1;
                    end
                    CFG_CROP_LEFT: begin
                        r_cfg_l <= i_cfg_data[POS_CFG_W-1:0];
                        r_restart_due <= 1'b1;
                    end
                    CFG_CROP_TOP: begin
                        r_cfg_top <= i_cfg_data[POS_CFG_W-1:0];
                        r_restart_due <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Position and window state; the restart load is only ever reached through
    // the controller, so these need no reset of their own.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_s_axis_tdata;
        end
        if (i_cmd.rst_load) begin
            r_eff_w     <= eff_w_c;
            r_eff_h     <= eff_h_c;
            r_eff_c     <= eff_c_c;
            r_eff_t     <= eff_t_c;
            r_sc        <= '0;
            r_sr        <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_q1        <= EDGE_W'(div_quot);
            r_col_start <= cl_e;
            r_col_end   <= cl_e + EDGE_W'(div_quot);
            r_row_end   <= ct_e + EDGE_W'(div_quot);
            r_band      <= 1'b1;
        end
        if (i_cmd.update) begin
            r_acc_sum <= new_sum;
            r_acc_cnt <= new_cnt;
            r_ex      <= COORD_W'(r_ocol);
            r_ey      <= COORD_W'(r_orow);
            r_elast   <= last_x && last_y;
        end
        if (i_cmd.ch_store) begin
            case (i_cmd.ch)
                CH_RED:   r_avg[0] <= div_quot[7:0];
                CH_GREEN: r_avg[1] <= div_quot[7:0];
                default:  r_avg[2] <= div_quot[7:0];
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_ey, r_ex, r_avg[0][7:3], r_avg[1][7:2], r_avg[2][7:3]};
            r_out_last <= r_elast;
        end
        if (i_cmd.adv) begin
            r_kind_row <= row_wrap;
            if (row_wrap) begin
                if (inrow) begin
                    r_band <= row_step;
                end
                if (row_step) begin
                    r_orow <= r_orow + T_W'(1);
                end
                if (!last_row) begin
                    r_sr        <= r_sr + SRC_W'(1);
                    r_sc        <= '0;
                    r_ocol      <= '0;
                    r_col_start <= cl_e;
                    r_col_end   <= cl_e + r_q1;
                end
            end else begin
                r_sc <= r_sc + SRC_W'(1);
                if (col_step) begin
                    r_ocol      <= r_ocol + T_W'(1);
                    r_col_start <= r_col_end;
                end
            end
        end
        if (i_cmd.adv_store) begin
            if (r_kind_row) begin
                r_row_end <= ct_e + EDGE_W'(div_quot);
            end else begin
                r_col_end <= cl_e + EDGE_W'(div_quot);
            end
        end
    end

    // accumulator memory: registered read, at most one write per item, made only inside the crop window
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_sum <= r_mem_sum[addr];
            r_rd_cnt <= r_mem_cnt[addr];
        end
        if (i_cmd.update && incol && inrow) begin
            r_mem_sum[addr] <= new_sum;
            r_mem_cnt[addr] <= new_cnt;
        end
    end

    always_comb begin
        o_status.restart_due = r_restart_due || i_s_axis_tuser;
        o_status.div_done    = div_done;
        o_status.emit        = emit;
        o_status.out_full    = r_out_valid;
        o_status.adv_div     = adv_div;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/rgbad_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbad_ctrl: sequencer of the downscaler
// Steps one item through restart when due, accumulate, average when a pixel completes, and advance.
// ----------------------------------------------------------------------------
module rgbad_ctrl
    import rgbad_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDIV  = 4'd1;
    localparam logic [3:0] S_RWAIT = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_UPD   = 4'd4;
    localparam logic [3:0] S_CDIV  = 4'd5;
    localparam logic [3:0] S_CWAIT = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_ADV   = 4'd8;
    localparam logic [3:0] S_AWAIT = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_ch, n_ch;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_ch       = r_ch;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.restart_due ? S_RDIV : S_READ;
                end
            end
            S_RDIV: begin
                o_cmd.rst_div = 1'b1;
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.rst_load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (i_status.emit) begin
                    n_ch    = CH_RED;
                    n_state = S_CDIV;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_CDIV: begin
                o_cmd.ch_div = 1'b1;
                o_cmd.ch     = r_ch;
                n_state = S_CWAIT;
            end
            S_CWAIT: begin
                o_cmd.ch = r_ch;
                if (i_status.div_done) begin
                    o_cmd.ch_store = 1'b1;
                    if (r_ch == CH_BLUE) begin
                        n_state = S_OUT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_CDIV;
                    end
                end
            end
            S_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state = i_status.adv_div ? S_AWAIT : S_IDLE;
            end
            S_AWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.adv_store = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= CH_RED;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rgb565_area_average_downscale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb565_area_average_downscale: box-filter downscaler for RGB565 frames
// Averages square windows of a crop region into an output image.
//
//  channel  | dir | signals              | content
//  s_axis   | in  | tvalid tready tdata  | tdata: source_pixel; tuser: frame_start
//  m_axis   | out | tvalid tready tdata  | tdata: out_pixel, out_x, out_y; tlast: frame_end
//  cfg      | in  | we index data        | six geometry registers, write only
//
// An item steps through accept, memory read, update and advance. Moving to the
// next column or row window adds a division, an output pixel one per channel
// and the output load, a frame restart one. The shared divider, 21 bits wide at
// default parameters, yields one quotient bit per cycle. Reset is synchronous;
// the accumulator memory is not cleared. The next item is taken while a result
// waits in the output register; a new result waits until it is free.
// ----------------------------------------------------------------------------
module rgb565_area_average_downscale
    import rgbad_pkg::*;
#(
    parameter int MAX_TARGET = DEF_MAX_TARGET,
    parameter int MAX_SOURCE = DEF_MAX_SOURCE,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // source_pixel
    input  wire logic                   i_s_axis_tuser,   // frame_start
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,   // out_pixel, out_x, out_y, pad
    output logic                        o_m_axis_tlast
);
    t_cmd    cmd;
    t_status status;

    rgbad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    rgbad_dp #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_SOURCE (MAX_SOURCE),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (cmd),
        .o_status        (status)
    );

endmodule
`default_nettype wire

// ===== rtl/rgbad_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgbad_chk: port-level checks of the downscaler
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module rgbad_chk
    import rgbad_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                   o_m_axis_tlast
);
    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Items are worked one at a time, so the input closes after each accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    // A result only appears while an item is in work.
    a_result_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !o_s_axis_tready)
        else $error("result appeared with no item in work");

endmodule

bind rgb565_area_average_downscale rgbad_chk u_chk (.*);
`default_nettype wire
